// File: rtl/core/decision_stump_train_core_defines.svh
// ----------------------------------------------------------------------------
// decision stump trainer assertion macros
// shared assertion shorthands, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef DECISION_STUMP_TRAIN_CORE_DEFINES_SVH
`define DECISION_STUMP_TRAIN_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define DST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DST_ASSERT_IMP(lbl, ante, cons, msg)
`define DST_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/core/dst_pkg.sv
// ----------------------------------------------------------------------------
// dst_pkg
// constants, types and state codes of the decision stump trainer
// ----------------------------------------------------------------------------
`default_nettype none

package dst_pkg;

  // capacity
  localparam int unsigned MAX_SAMPLES  = 1024;
  localparam int unsigned MAX_FEATURES = 16;

  // derived widths
  localparam int unsigned SIW = $clog2(MAX_SAMPLES);
  localparam int unsigned SCW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned FIW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned PW  = $clog2(MAX_FEATURES + 1);
  localparam int unsigned FAW = SIW + FIW;
  localparam int unsigned FEAT_DEPTH = MAX_SAMPLES * (1 << FIW);

  // field widths
  localparam int unsigned KEY_W = 32;
  localparam int unsigned WGT_W = 32;
  localparam int unsigned ACC_W = 42;
  localparam int unsigned BF_W  = 4;

  localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};
  localparam logic [KEY_W-1:0] SIGN_FLIP = 32'h8000_0000;
  localparam logic [KEY_W-1:0] MINUS_INF = 32'h8000_0000;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_ZFILL,
    ST_FEAT,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_SRT_RD,
    ST_SRT_KEY,
    ST_SRT_RDJ,
    ST_SRT_CMP,
    ST_SRT_INS,
    ST_INF,
    ST_SW_RDA,
    ST_SW_RDB,
    ST_SW_ADD,
    ST_SW_SUB,
    ST_SW_E1,
    ST_SW_E0,
    ST_SW_PICK,
    ST_NEXT,
    ST_DONE
  } dst_state_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } dst_alu_op_e;

  typedef struct packed {
    dst_alu_op_e      op;
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
  } dst_alu_req_t;

endpackage

`default_nettype wire

// File: rtl/core/dst_in_if.sv
// ----------------------------------------------------------------------------
// dst_in_if
// sample value channel of the decision stump trainer
// ----------------------------------------------------------------------------
`default_nettype none

interface dst_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] feature_value;
  logic        label;
  logic [31:0] weight;
  logic        last_of_sample;
  logic        last_sample;

  modport source (
    output valid, feature_value, label, weight, last_of_sample, last_sample,
    input  ready
  );
  modport sink (
    input  valid, feature_value, label, weight, last_of_sample, last_sample,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/dst_out_if.sv
// ----------------------------------------------------------------------------
// dst_out_if
// trained stump channel of the decision stump trainer
// ----------------------------------------------------------------------------
`default_nettype none

interface dst_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  best_feature;
  logic [31:0] threshold;
  logic        direction;
  logic [41:0] weighted_err;
  logic        overflow;

  modport source (
    output valid, best_feature, threshold, direction, weighted_err, overflow,
    input  ready
  );
  modport sink (
    input  valid, best_feature, threshold, direction, weighted_err, overflow,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/dst_ram.sv
// ----------------------------------------------------------------------------
// dst_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module dst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/dst_alu.sv
// ----------------------------------------------------------------------------
// dst_alu
// shared saturating add / floor-at-zero subtract for the weight sums
// ----------------------------------------------------------------------------
`default_nettype none

module dst_alu import dst_pkg::*; (
  input  wire dst_alu_req_t     req_i,
  output logic [ACC_W-1:0]      res_o
);

  logic [ACC_W:0] sum;

  assign sum = {1'b0, req_i.a} + {1'b0, req_i.b};

  // saturate on add, clamp at zero on subtract
  always_comb begin
    case (req_i.op)
      ALU_ADD: res_o = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
      ALU_SUB: res_o = (req_i.a > req_i.b) ? (req_i.a - req_i.b) : '0;
      default: res_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/decision_stump_train_core.sv
// ----------------------------------------------------------------------------
// decision_stump_train_core
// weighted decision stump trainer: loads samples, then sorts and sweeps
// every feature with one shared saturating adder to find the best stump
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// samp_i    in   valid/ready        feature_value label weight last_of_sample
//                                   last_sample
// stump_o   out  valid/ready        best_feature threshold direction weighted_err
//                                   overflow
//
// loading takes one feature value per cycle while samp_i is ready; a short
// sample is padded with zeros at one value per cycle before the next value
// is taken. training runs per feature a setup step, a sum pass over the
// samples, an insertion sort (read and key each sample, read and compare
// sorted keys, insert), the minus infinity candidate, a sweep over the
// midpoints and a feature step, all set by the single read port of each ram
// and the shared adder. samp_i is not ready during padding and training; the
// result sits in an output register so a new set can load while it waits.
// reset clears the counters, flags and output valid; rams are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decision_stump_train_core_defines.svh"

module decision_stump_train_core import dst_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dst_in_if.sink     samp_i,
  dst_out_if.source  stump_o
);

  dst_state_e state_q, state_d;

  // load state
  logic [SCW-1:0] scnt_q;
  logic [PW-1:0]  fcnt_q;
  logic [PW-1:0]  pos_q;
  logic           ovf_q;
  logic           pend_q;
  logic [SIW-1:0] zrow_q;
  logic [PW-1:0]  zp_q;

  // training state
  logic [FIW-1:0]   f_q;
  logic [SCW-1:0]   n_q;
  logic [SIW-1:0]   j_q;
  logic [KEY_W-1:0] key_q, ka_q, kb_q;
  logic [WGT_W-1:0] w_q;
  logic             lab_q;
  logic [ACC_W-1:0] s0_q, s1_q, s2_q, s3_q, e1_q, e0_q;
  logic [ACC_W-1:0] best_err_q;
  logic [FIW-1:0]   best_f_q;
  logic [KEY_W-1:0] best_thr_q;
  logic             best_dir_q;

  // output register
  logic             out_valid_q;
  logic [BF_W-1:0]  out_bf_q;
  logic [KEY_W-1:0] out_thr_q;
  logic             out_dir_q;
  logic [ACC_W-1:0] out_err_q;
  logic             out_ovf_q;

  // ram ports
  logic             feat_we, samp_we, sk_we;
  logic [FAW-1:0]   feat_waddr, feat_raddr;
  logic [KEY_W-1:0] feat_wdata, feat_rdata;
  logic [SIW-1:0]   samp_waddr, samp_raddr, sk_waddr, sk_raddr;
  logic [WGT_W:0]   samp_wdata, samp_rdata;
  logic [KEY_W-1:0] skey_wdata, skey_rdata;
  logic [SIW-1:0]   sidx_wdata, sidx_rdata;

  dst_alu_req_t     alu_req;
  logic [ACC_W-1:0] alu_res;

  // load decode
  logic           in_acc, stored, fv_ok, need_fill, done_go;
  logic [PW-1:0]  limit;
  logic [PW:0]    pos1;
  logic [SCW-1:0] n1;
  logic [PW-1:0]  f1;

  assign in_acc    = samp_i.valid && samp_i.ready;
  assign stored    = scnt_q < SCW'(MAX_SAMPLES);
  assign limit     = (scnt_q == '0) ? PW'(MAX_FEATURES) : fcnt_q;
  assign fv_ok     = pos_q < limit;
  assign pos1      = {1'b0, pos_q} + 1'b1;
  assign need_fill = stored && samp_i.last_of_sample && (scnt_q != '0)
                     && (pos1 < {1'b0, fcnt_q});
  assign n1        = n_q + 1'b1;
  assign f1        = PW'(f_q) + 1'b1;
  assign done_go   = !out_valid_q || stump_o.ready;

  // sweep candidate
  logic [KEY_W:0]   mid_sum;
  logic [KEY_W-1:0] mid_thr;
  logic             pick_e1, inf_lo;

  assign mid_sum = {1'b0, ka_q} + {1'b0, kb_q};
  assign mid_thr = mid_sum[KEY_W:1] ^ SIGN_FLIP;
  assign pick_e1 = e1_q <= e0_q;
  assign inf_lo  = s2_q <= s3_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && samp_i.last_of_sample) begin
          if (need_fill) begin
            state_d = ST_ZFILL;
          end else if (samp_i.last_sample) begin
            state_d = ST_FEAT;
          end
        end
      end
      ST_ZFILL: begin
        if (zp_q + 1'b1 == fcnt_q) begin
          state_d = pend_q ? ST_FEAT : ST_LOAD;
        end
      end
      ST_FEAT:    state_d = (fcnt_q == '0) ? ST_DONE :
                            (scnt_q == '0) ? ST_INF : ST_SUM_RD;
      ST_SUM_RD:  state_d = ST_SUM_ACC;
      ST_SUM_ACC: state_d = (n1 == scnt_q) ? ST_SRT_RD : ST_SUM_RD;
      ST_SRT_RD:  state_d = ST_SRT_KEY;
      ST_SRT_KEY: state_d = (n_q == '0) ? ST_SRT_INS : ST_SRT_RDJ;
      ST_SRT_RDJ: state_d = ST_SRT_CMP;
      ST_SRT_CMP: begin
        if (skey_rdata > key_q) begin
          state_d = (j_q == SIW'(1)) ? ST_SRT_INS : ST_SRT_RDJ;
        end else begin
          state_d = ST_SRT_INS;
        end
      end
      ST_SRT_INS: state_d = (n1 == scnt_q) ? ST_INF : ST_SRT_RD;
      ST_INF:     state_d = (scnt_q <= SCW'(1)) ? ST_NEXT : ST_SW_RDA;
      ST_SW_RDA:  state_d = ST_SW_RDB;
      ST_SW_RDB:  state_d = ST_SW_ADD;
      ST_SW_ADD:  state_d = ST_SW_SUB;
      ST_SW_SUB:  state_d = ST_SW_E1;
      ST_SW_E1:   state_d = ST_SW_E0;
      ST_SW_E0:   state_d = ST_SW_PICK;
      ST_SW_PICK: state_d = (n1 == scnt_q) ? ST_NEXT : ST_SW_RDA;
      ST_NEXT:    state_d = (f1 == fcnt_q) ? ST_DONE : ST_FEAT;
      ST_DONE:    state_d = done_go ? ST_LOAD : ST_DONE;
      default:    state_d = ST_LOAD;
    endcase
  end

  // ram and adder controls
  always_comb begin
    feat_we    = 1'b0;
    feat_waddr = {scnt_q[SIW-1:0], pos_q[FIW-1:0]};
    feat_wdata = samp_i.feature_value;
    feat_raddr = {n_q[SIW-1:0], f_q};
    samp_we    = 1'b0;
    samp_waddr = scnt_q[SIW-1:0];
    samp_wdata = {samp_i.label, samp_i.weight};
    samp_raddr = n_q[SIW-1:0];
    sk_we      = 1'b0;
    sk_waddr   = j_q;
    skey_wdata = skey_rdata;
    sidx_wdata = sidx_rdata;
    sk_raddr   = j_q - 1'b1;
    alu_req.op = ALU_ADD;
    alu_req.a  = s0_q;
    alu_req.b  = s3_q;
    case (state_q)
      ST_LOAD: begin
        feat_we = in_acc && stored && fv_ok;
        samp_we = in_acc && stored && (pos_q == '0);
      end
      ST_ZFILL: begin
        feat_we    = 1'b1;
        feat_waddr = {zrow_q, zp_q[FIW-1:0]};
        feat_wdata = '0;
      end
      ST_SUM_ACC: begin
        alu_req.a = samp_rdata[WGT_W] ? s2_q : s3_q;
        alu_req.b = ACC_W'(samp_rdata[WGT_W-1:0]);
      end
      ST_SRT_CMP: begin
        sk_we = skey_rdata > key_q;
      end
      ST_SRT_INS: begin
        sk_we      = 1'b1;
        skey_wdata = key_q;
        sidx_wdata = n_q[SIW-1:0];
      end
      ST_SW_RDA: begin
        sk_raddr = n_q[SIW-1:0] - 1'b1;
      end
      ST_SW_RDB: begin
        sk_raddr   = n_q[SIW-1:0];
        samp_raddr = sidx_rdata;
      end
      ST_SW_ADD: begin
        alu_req.a = samp_rdata[WGT_W] ? s0_q : s1_q;
        alu_req.b = ACC_W'(samp_rdata[WGT_W-1:0]);
      end
      ST_SW_SUB: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = lab_q ? s2_q : s3_q;
        alu_req.b  = ACC_W'(w_q);
      end
      ST_SW_E0: begin
        alu_req.a = s1_q;
        alu_req.b = s2_q;
      end
      default: begin
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // load counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scnt_q <= '0;
      fcnt_q <= '0;
      pos_q  <= '0;
      ovf_q  <= 1'b0;
      pend_q <= 1'b0;
      zp_q   <= '0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (!stored || !fv_ok) begin
              ovf_q <= 1'b1;
            end
            if (stored && fv_ok && (scnt_q == '0)) begin
              fcnt_q <= pos1[PW-1:0];
            end
            if (samp_i.last_of_sample) begin
              if (stored) begin
                scnt_q <= scnt_q + 1'b1;
              end
              pos_q  <= '0;
              pend_q <= samp_i.last_sample;
              zp_q   <= pos1[PW-1:0];
            end else if (pos_q < PW'(MAX_FEATURES)) begin
              pos_q <= pos_q + 1'b1;
            end
          end
        end
        ST_ZFILL: zp_q <= zp_q + 1'b1;
        ST_DONE: begin
          if (done_go) begin
            scnt_q <= '0;
            fcnt_q <= '0;
            pos_q  <= '0;
            ovf_q  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // pad row
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      zrow_q <= scnt_q[SIW-1:0];
    end
  end

  // training datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q        <= '0;
      n_q        <= '0;
      j_q        <= '0;
      s0_q       <= '0;
      s1_q       <= '0;
      s2_q       <= '0;
      s3_q       <= '0;
      best_err_q <= ACC_MAX;
      best_f_q   <= '0;
      best_thr_q <= '0;
      best_dir_q <= 1'b0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          f_q <= '0;
          n_q <= '0;
        end
        ST_FEAT: begin
          n_q  <= '0;
          s0_q <= '0;
          s1_q <= '0;
          s2_q <= '0;
          s3_q <= '0;
        end
        ST_SUM_ACC: begin
          if (samp_rdata[WGT_W]) begin
            s2_q <= alu_res;
          end else begin
            s3_q <= alu_res;
          end
          n_q <= (n1 == scnt_q) ? '0 : n1;
        end
        ST_SRT_KEY: j_q <= n_q[SIW-1:0];
        ST_SRT_CMP: begin
          if (skey_rdata > key_q) begin
            j_q <= j_q - 1'b1;
          end
        end
        ST_SRT_INS: n_q <= n1;
        ST_INF: begin
          if ((inf_lo ? s2_q : s3_q) <= best_err_q) begin
            best_err_q <= inf_lo ? s2_q : s3_q;
            best_f_q   <= f_q;
            best_thr_q <= MINUS_INF;
            best_dir_q <= !inf_lo;
          end
          n_q <= SCW'(1);
        end
        ST_SW_ADD: begin
          if (samp_rdata[WGT_W]) begin
            s0_q <= alu_res;
          end else begin
            s1_q <= alu_res;
          end
        end
        ST_SW_SUB: begin
          if (lab_q) begin
            s2_q <= alu_res;
          end else begin
            s3_q <= alu_res;
          end
        end
        ST_SW_PICK: begin
          if ((pick_e1 ? e1_q : e0_q) <= best_err_q) begin
            best_err_q <= pick_e1 ? e1_q : e0_q;
            best_f_q   <= f_q;
            best_thr_q <= mid_thr;
            best_dir_q <= pick_e1;
          end
          n_q <= n1;
        end
        ST_NEXT: f_q <= f_q + 1'b1;
        ST_DONE: begin
          if (done_go) begin
            best_err_q <= ACC_MAX;
            best_f_q   <= '0;
            best_thr_q <= '0;
            best_dir_q <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // operand latches
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_SRT_KEY: key_q <= feat_rdata ^ SIGN_FLIP;
      ST_SW_RDB:  ka_q <= skey_rdata;
      ST_SW_ADD: begin
        kb_q  <= skey_rdata;
        w_q   <= samp_rdata[WGT_W-1:0];
        lab_q <= samp_rdata[WGT_W];
      end
      ST_SW_E1:   e1_q <= alu_res;
      ST_SW_E0:   e0_q <= alu_res;
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && stump_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == ST_DONE) && done_go) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && done_go) begin
      out_bf_q  <= BF_W'(best_f_q);
      out_thr_q <= best_thr_q;
      out_dir_q <= best_dir_q;
      out_err_q <= best_err_q;
      out_ovf_q <= ovf_q;
    end
  end

  assign samp_i.ready         = state_q == ST_LOAD;
  assign stump_o.valid        = out_valid_q;
  assign stump_o.best_feature = out_bf_q;
  assign stump_o.threshold    = out_thr_q;
  assign stump_o.direction    = out_dir_q;
  assign stump_o.weighted_err = out_err_q;
  assign stump_o.overflow     = out_ovf_q;

  // shared adder
  dst_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  // feature values, one row of features per sample
  dst_ram #(.Width(KEY_W), .Depth(FEAT_DEPTH)) u_feat_ram (
    .clk_i   (clk_i),
    .we_i    (feat_we),
    .waddr_i (feat_waddr),
    .wdata_i (feat_wdata),
    .raddr_i (feat_raddr),
    .rdata_o (feat_rdata)
  );

  // label and weight per sample
  dst_ram #(.Width(WGT_W + 1), .Depth(MAX_SAMPLES)) u_samp_ram (
    .clk_i   (clk_i),
    .we_i    (samp_we),
    .waddr_i (samp_waddr),
    .wdata_i (samp_wdata),
    .raddr_i (samp_raddr),
    .rdata_o (samp_rdata)
  );

  // sorted keys
  dst_ram #(.Width(KEY_W), .Depth(MAX_SAMPLES)) u_skey_ram (
    .clk_i   (clk_i),
    .we_i    (sk_we),
    .waddr_i (sk_waddr),
    .wdata_i (skey_wdata),
    .raddr_i (sk_raddr),
    .rdata_o (skey_rdata)
  );

  // sorted sample indexes
  dst_ram #(.Width(SIW), .Depth(MAX_SAMPLES)) u_sidx_ram (
    .clk_i   (clk_i),
    .we_i    (sk_we),
    .waddr_i (sk_waddr),
    .wdata_i (sidx_wdata),
    .raddr_i (sk_raddr),
    .rdata_o (sidx_rdata)
  );

  // checks
  `DST_ASSERT_IMP(a_fcnt_cap, 1'b1, fcnt_q <= PW'(MAX_FEATURES), "feature count over capacity")
  `DST_ASSERT_IMP(a_n_bound, state_q != ST_LOAD && state_q != ST_ZFILL, n_q <= scnt_q,
                  "sample counter past stored samples")
  `DST_ASSERT_IMP(a_j_bound, state_q == ST_SRT_CMP || state_q == ST_SRT_RDJ,
                  SCW'(j_q) <= n_q && j_q != '0, "sort slot out of range")
  `DST_ASSERT_NXT(a_best_mono, state_q == ST_SW_PICK, best_err_q <= $past(best_err_q),
                  "best error grew during sweep")

endmodule

`default_nettype wire

// File: tb/decision_stump_train_core_tb.sv
// ----------------------------------------------------------------------------
// decision_stump_train_core_tb
// loads sample sets through the input channel and checks each trained stump
// against an in-bench predictor; random burst/gap sending, receiver stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decision_stump_train_core_tb;
  import dst_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned HOLD_CYCLES  = 3000;

  typedef struct {
    logic [31:0] fv;
    logic        label;
    logic [31:0] weight;
    logic        los;
    logic        ls;
  } sample_value_t;

  typedef struct {
    logic [3:0]       feature;
    logic [31:0]      threshold;
    logic             direction;
    logic [ACC_W-1:0] err;
    logic             overflow;
  } stump_t;

  logic clk_i;
  logic rst_ni;

  dst_in_if  samp();
  dst_out_if stump();

  decision_stump_train_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .samp_i  (samp),
    .stump_o (stump)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0]      feat_mem [MAX_SAMPLES*MAX_FEATURES];
  logic             label_mem [MAX_SAMPLES];
  logic [31:0]      weight_mem [MAX_SAMPLES];
  int unsigned      order_mem [MAX_SAMPLES];
  int unsigned      n_samples;
  int unsigned      n_features;
  int unsigned      value_pos;
  logic             dropped;
  stump_t           stump_q[$];

  int unsigned      n_errors;
  int unsigned      burst_left;
  bit               hold_req;
  int unsigned      idle_cycles;

  function automatic longint unsigned acc_add(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > longint'(ACC_MAX)) ? longint'(ACC_MAX) : s;
  endfunction

  function automatic longint unsigned acc_sub(longint unsigned a, longint unsigned b);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic logic [31:0] sort_key(int unsigned f, int unsigned n);
    return feat_mem[n*MAX_FEATURES + f] ^ SIGN_FLIP;
  endfunction

  // best stump search over the stored set
  function automatic stump_t train_stump();
    stump_t best;
    longint unsigned best_err, lp, ln, rp, rn, e1, e0, w, cand;
    logic [32:0] pair_sum;
    logic [31:0] thr, key;
    logic cand_dir;
    int unsigned j, a, b;
    best_err = ACC_MAX;
    best.feature = '0;
    best.threshold = '0;
    best.direction = 1'b0;
    for (int unsigned f = 0; f < n_features && f < MAX_FEATURES; f++) begin
      lp = 0; ln = 0; rp = 0; rn = 0;
      for (int unsigned n = 0; n < n_samples; n++) begin
        if (label_mem[n]) rp = acc_add(rp, weight_mem[n]);
        else rn = acc_add(rn, weight_mem[n]);
      end
      // stable insertion sort
      for (int unsigned n = 0; n < n_samples; n++) begin
        key = sort_key(f, n);
        j = n;
        while (j > 0 && sort_key(f, order_mem[j-1]) > key) begin
          order_mem[j] = order_mem[j-1];
          j--;
        end
        order_mem[j] = n;
      end
      // minus infinity candidate, tie picks direction 0
      if (rp <= rn) begin cand = rp; cand_dir = 1'b0; end
      else begin cand = rn; cand_dir = 1'b1; end
      if (cand <= best_err) begin
        best_err = cand; best.feature = f[3:0]; best.threshold = MINUS_INF;
        best.direction = cand_dir;
      end
      // midpoints, tie picks direction 1
      for (int unsigned n = 1; n < n_samples; n++) begin
        a = order_mem[n-1];
        b = order_mem[n];
        pair_sum = {1'b0, sort_key(f, a)} + {1'b0, sort_key(f, b)};
        thr = pair_sum[32:1] ^ SIGN_FLIP;
        w = weight_mem[a];
        if (label_mem[a]) begin lp = acc_add(lp, w); rp = acc_sub(rp, w); end
        else begin ln = acc_add(ln, w); rn = acc_sub(rn, w); end
        e1 = acc_add(lp, rn);
        e0 = acc_add(ln, rp);
        if (e1 <= e0) begin cand = e1; cand_dir = 1'b1; end
        else begin cand = e0; cand_dir = 1'b0; end
        if (cand <= best_err) begin
          best_err = cand; best.feature = f[3:0]; best.threshold = thr;
          best.direction = cand_dir;
        end
      end
    end
    best.err = best_err[ACC_W-1:0];
    best.overflow = dropped;
    return best;
  endfunction

  // update the predictor with one accepted transaction
  function automatic void predict_value(sample_value_t it);
    bit stored;
    int unsigned lim;
    stored = n_samples < MAX_SAMPLES;
    if (!stored) begin
      dropped = 1'b1;
    end else begin
      lim = (n_samples == 0) ? MAX_FEATURES : n_features;
      if (value_pos == 0) begin
        label_mem[n_samples] = it.label;
        weight_mem[n_samples] = it.weight;
      end
      if (value_pos < lim && value_pos < MAX_FEATURES) begin
        feat_mem[n_samples*MAX_FEATURES + value_pos] = it.fv;
        if (n_samples == 0) n_features = value_pos + 1;
      end else begin
        dropped = 1'b1;
      end
    end
    if (it.los) begin
      if (stored) begin
        for (int unsigned p = value_pos + 1; p < n_features && p < MAX_FEATURES; p++)
          feat_mem[n_samples*MAX_FEATURES + p] = '0;
        n_samples++;
      end
      value_pos = 0;
    end else if (value_pos < MAX_FEATURES) begin
      value_pos++;
    end
    if (it.los && it.ls) begin
      stump_q.insert(stump_q.size(), train_stump());
      n_samples = 0;
      n_features = 0;
      value_pos = 0;
      dropped = 1'b0;
    end
  endfunction

  // send one value, with random bursts and gaps
  task automatic send_value(sample_value_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i) samp.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    samp.valid          <= 1'b1;
    samp.feature_value  <= it.fv;
    samp.label          <= it.label;
    samp.weight         <= it.weight;
    samp.last_of_sample <= it.los;
    samp.last_sample    <= it.ls;
    do @(posedge clk_i); while (!samp.ready);
    predict_value(it);
    burst_left--;
  endtask

  task automatic send_one(logic [31:0] fv, logic lab, logic [31:0] w, logic los, logic ls);
    sample_value_t it;
    it.fv = fv; it.label = lab; it.weight = w; it.los = los; it.ls = ls;
    send_value(it);
  endtask

  // stop offering and wait for every expected stump
  task automatic drain();
    @(negedge clk_i) samp.valid <= 1'b0;
    burst_left = 0;
    while (stump_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value(int unsigned mode);
    case (mode)
      0: return $urandom_range(0, 3) << 16;
      1: return ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // one random set; mostly well-formed, some short, long and noisy samples
  task automatic send_random_set(int unsigned n_samp, int unsigned n_feat,
                                 ref int unsigned sent);
    int unsigned vmode, cnt;
    logic lab;
    logic [31:0] w;
    vmode = $urandom_range(0, 2);
    for (int unsigned s = 0; s < n_samp; s++) begin
      cnt = n_feat;
      if (s > 0 && $urandom_range(0, 9) == 0) cnt = $urandom_range(1, n_feat);
      else if ($urandom_range(0, 19) == 0) cnt = n_feat + $urandom_range(1, 3);
      lab = $urandom_range(0, 1);
      w = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0100_0000);
      for (int unsigned v = 0; v < cnt; v++) begin
        send_one(rand_value(vmode), lab, w, v == cnt - 1,
                 (v == cnt - 1) ? (s == n_samp - 1) : ($urandom_range(0, 15) == 0));
        lab = $urandom_range(0, 1);
        w = $urandom();
        sent++;
      end
    end
  endtask

  // extremes, ties, short and long samples, lone last_sample
  task automatic test_directed();
    // single sample, only the minus infinity candidate
    send_one(32'h7fff_ffff, 1'b1, 32'hffff_ffff, 1'b1, 1'b1);
    // extremes; midpoint of the two lowest values reads as minus infinity
    send_one(32'h8000_0000, 1'b0, 32'h0100_0000, 1'b0, 1'b1);
    send_one(32'h7fff_ffff, 1'b0, 32'h0, 1'b1, 1'b0);
    send_one(32'h8000_0001, 1'b1, 32'h0200_0000, 1'b0, 1'b0);
    send_one(32'h8000_0000, 1'b1, 32'h0, 1'b1, 1'b0);
    send_one(32'h7fff_ffff, 1'b0, 32'hffff_ffff, 1'b0, 1'b0);
    send_one(32'h0000_0000, 1'b0, 32'h0, 1'b1, 1'b1);
    // ties and a short later sample
    send_one(32'h0001_0000, 1'b1, 32'h0100_0000, 1'b0, 1'b0);
    send_one(32'h0001_0000, 1'b1, 32'h0100_0000, 1'b1, 1'b0);
    send_one(32'h0001_0000, 1'b0, 32'h0100_0000, 1'b1, 1'b0);
    send_one(32'hffff_0000, 1'b0, 32'h0080_0000, 1'b0, 1'b0);
    send_one(32'h0002_0000, 1'b0, 32'h0, 1'b0, 1'b0);
    send_one(32'h1234_5678, 1'b0, 32'h0, 1'b1, 1'b1);
    // first sample longer than capacity
    for (int unsigned v = 0; v < MAX_FEATURES + 2; v++)
      send_one($urandom(), 1'b1, 32'h0300_0000, v == MAX_FEATURES + 1, 1'b0);
    send_one(32'h0, 1'b0, 32'h0100_0000, 1'b1, 1'b1);
    drain();
  endtask

  // more samples than capacity, equal keys keep the sort short
  task automatic test_sample_overflow();
    for (int unsigned s = 0; s <= MAX_SAMPLES; s++)
      send_one(32'h0004_0000, s[0], 32'hffff_ffff, 1'b1, s == MAX_SAMPLES);
    drain();
  endtask

  // receiver holds off while several sets are offered
  task automatic test_backpressure();
    int unsigned sent;
    hold_req = 1'b1;
    for (int unsigned k = 0; k < 4; k++) send_random_set(3, 2, sent);
    drain();
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned ns, nf;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        ns = $urandom_range(20, 40); nf = $urandom_range(1, MAX_FEATURES);
      end else begin
        ns = $urandom_range(1, 10); nf = $urandom_range(1, 5);
      end
      send_random_set(ns, nf, sent);
      if ($urandom_range(0, 15) == 0) drain();
    end
    drain();
  endtask

  // receiver stall pattern, with a long hold on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      stump.ready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      hold_req = 1'b0;
    end else begin
      case (($time / 256) % 3)
        0: stump.ready <= 1'b1;
        1: stump.ready <= $urandom_range(0, 1);
        default: stump.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // check each result transaction
  always @(posedge clk_i) begin
    stump_t e;
    if (rst_ni && stump.valid && stump.ready) begin
      if (stump_q.size() == 0) begin
        $display("%0t: unexpected stump f=%0d thr=%h dir=%b err=%h ovf=%b", $time,
                 stump.best_feature, stump.threshold, stump.direction, stump.weighted_err,
                 stump.overflow);
        n_errors++;
      end else begin
        e = stump_q.pop_front();
        if (stump.best_feature !== e.feature) begin
          $display("%0t: best_feature exp %0d got %0d", $time, e.feature, stump.best_feature);
          n_errors++;
        end
        if (stump.threshold !== e.threshold) begin
          $display("%0t: threshold exp %h got %h", $time, e.threshold, stump.threshold);
          n_errors++;
        end
        if (stump.direction !== e.direction) begin
          $display("%0t: direction exp %b got %b", $time, e.direction, stump.direction);
          n_errors++;
        end
        if (stump.weighted_err !== e.err) begin
          $display("%0t: weighted_err exp %h got %h", $time, e.err, stump.weighted_err);
          n_errors++;
        end
        if (stump.overflow !== e.overflow) begin
          $display("%0t: overflow exp %b got %b", $time, e.overflow, stump.overflow);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((samp.valid && samp.ready) || (stump.valid && stump.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog timeout at %0t", $time);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    samp.valid = 1'b0;
    samp.feature_value = '0;
    samp.label = 1'b0;
    samp.weight = '0;
    samp.last_of_sample = 1'b0;
    samp.last_sample = 1'b0;
    stump.ready = 1'b0;
    hold_req = 1'b0;
    n_errors = 0;
    burst_left = 0;
    idle_cycles = 0;
    n_samples = 0;
    n_features = 0;
    value_pos = 0;
    dropped = 1'b0;
    foreach (feat_mem[i]) feat_mem[i] = '0;
    foreach (label_mem[i]) label_mem[i] = 1'b0;
    foreach (weight_mem[i]) weight_mem[i] = '0;
    foreach (order_mem[i]) order_mem[i] = 0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    test_directed();
    test_sample_overflow();
    test_backpressure();
    test_random();

    repeat (200) @(posedge clk_i);
    if (n_errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
